>>> design/tpe_pkg.sv
// Shared constants and types for the TCP payload extractor.
package tpe_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;

  // Frame byte positions and header limits.
  localparam int unsigned ETH_HDR_BYTES   = 14;
  localparam int unsigned IP_LEN_HI_POS   = 16;
  localparam int unsigned IP_LEN_LO_POS   = 17;
  localparam int unsigned IP_PROTO_POS    = 23;
  localparam int unsigned TCP_OFF_BASE    = ETH_HDR_BYTES + 12;
  localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_IP_HLEN  = 3'd1,
    ST_NOT_TCP      = 3'd2,
    ST_BAD_TCP_HLEN = 3'd3,
    ST_NO_PAYLOAD   = 3'd4,
    ST_TRUNCATED    = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] payload_length;
    status_e     frame_status;
    logic        frame_done;
    logic        payload_last;
    logic        payload_valid;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

>>> design/tcp_payload_extractor.sv
// Result words go to the output register, or to the skid register while that one is stalled.
// One frame word per cycle while skid is empty; the header parse is one compare/subtract stage.
// A two-entry output buffer (result register plus skid register) keeps s_axis_tready registered.
// Reset (rst_ni low, asynchronous) clears the parse state and empties both output registers.
// The parse state also returns to its reset value after every word marked with tlast.
module tcp_payload_extractor
  import tpe_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                      // [26:11] payload_length, [31:27] zero
  output logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] frame_done
  output logic        m_axis_tlast    // payload_last
);

  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW : 8;

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      ihw_q, ihw_d;
  logic [15:0]     tl_q, tl_d;
  logic [3:0]      thw_q, thw_d;
  logic [15:0]     rem_q, rem_d;
  status_e         verdict_q, verdict_d;

  logic            in_fire;
  logic            active;
  logic [CmpW-1:0] pos_c;
  logic [CmpW-1:0] tcp_off;
  logic [CmpW-1:0] hdr_end;
  logic            off_hit;
  logic [3:0]      thw_sel;
  logic [16:0]     sz;
  logic            sz_pos;
  logic            res_valid;
  result_t         res;

  logic            out_valid_q, skid_valid_q;
  result_t         out_q, skid_q;
  logic            out_fire;

  assign in_fire = s_axis_tvalid & s_axis_tready;
  assign active  = (pos_q < PosW'(MaxFrameBytes)) && (verdict_q == ST_OK);
  assign pos_c   = CmpW'(pos_q);
  assign tcp_off = CmpW'(TCP_OFF_BASE) + CmpW'({ihw_q, 2'b00});
  assign hdr_end = CmpW'(ETH_HDR_BYTES) + CmpW'({5'(ihw_q) + 5'(thw_q), 2'b00});

  // The data offset position only matches once the IP header length is known.
  assign off_hit = active && (pos_c != CmpW'(ETH_HDR_BYTES)) && (pos_c != CmpW'(IP_LEN_HI_POS))
                   && (pos_c != CmpW'(IP_LEN_LO_POS)) && (pos_c != CmpW'(IP_PROTO_POS))
                   && (pos_c > CmpW'(ETH_HDR_BYTES)) && (pos_c == tcp_off);
  assign thw_sel = off_hit ? s_axis_tdata[7:4] : thw_q;
  assign sz      = {1'b0, tl_q} - 17'({5'(ihw_q) + 5'(thw_sel), 2'b00});
  assign sz_pos  = !sz[16] && (sz[15:0] != 16'd0);

  always_comb begin
    pos_d     = pos_q;
    ihw_d     = ihw_q;
    tl_d      = tl_q;
    thw_d     = thw_q;
    rem_d     = rem_q;
    verdict_d = verdict_q;
    res       = '0;
    if (active) begin
      if (pos_c == CmpW'(ETH_HDR_BYTES)) begin
        ihw_d = s_axis_tdata[3:0];
        if (s_axis_tdata[3:0] < MIN_HDR_WORDS) verdict_d = ST_BAD_IP_HLEN;
      end else if (pos_c == CmpW'(IP_LEN_HI_POS)) begin
        tl_d = {s_axis_tdata, tl_q[7:0]};
      end else if (pos_c == CmpW'(IP_LEN_LO_POS)) begin
        tl_d = {tl_q[15:8], s_axis_tdata};
      end else if (pos_c == CmpW'(IP_PROTO_POS)) begin
        if (s_axis_tdata != PROTO_TCP) verdict_d = ST_NOT_TCP;
      end else if (off_hit) begin
        thw_d = s_axis_tdata[7:4];
        if (s_axis_tdata[7:4] < MIN_HDR_WORDS) begin
          verdict_d = ST_BAD_TCP_HLEN;
        end else if (sz_pos) begin
          rem_d = sz[15:0];
        end else begin
          verdict_d = ST_NO_PAYLOAD;
        end
      end else if ((rem_q != 16'd0) && (pos_c >= hdr_end)) begin
        res.payload_valid = 1'b1;
        res.payload_byte  = s_axis_tdata;
        res.payload_last  = (rem_q == 16'd1) || s_axis_tlast;
        rem_d             = rem_q - 16'd1;
      end
    end
    if (pos_q < PosW'(MaxFrameBytes)) pos_d = pos_q + PosW'(1);

    if (s_axis_tlast) begin
      res.frame_done = 1'b1;
      if (verdict_d != ST_OK) begin
        res.frame_status = verdict_d;
      end else if ((thw_d == 4'd0) || (rem_d != 16'd0)) begin
        res.frame_status = ST_TRUNCATED;
      end
      if ((thw_d >= MIN_HDR_WORDS) && sz_pos) res.payload_length = sz[15:0];
      pos_d     = '0;
      ihw_d     = '0;
      tl_d      = '0;
      thw_d     = '0;
      rem_d     = '0;
      verdict_d = ST_OK;
    end
  end

  assign res_valid = res.payload_valid | res.frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ihw_q     <= '0;
      tl_q      <= '0;
      thw_q     <= '0;
      rem_q     <= '0;
      verdict_q <= ST_OK;
    end else if (in_fire) begin
      pos_q     <= pos_d;
      ihw_q     <= ihw_d;
      tl_q      <= tl_d;
      thw_q     <= thw_d;
      rem_q     <= rem_d;
      verdict_q <= verdict_d;
    end
  end

  // Output word register with a skid register behind it.
  assign out_fire      = out_valid_q & m_axis_tready;
  assign s_axis_tready = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) skid_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire && res_valid) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.payload_length, out_q.frame_status, out_q.payload_byte};
  assign m_axis_tuser  = {out_q.frame_done, out_q.payload_valid};
  assign m_axis_tlast  = out_q.payload_last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a word while the output register is empty");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (pos_q == '0) && (rem_q == 16'd0) && (verdict_q == ST_OK))
    else $error("parse state not cleared after the last frame word");

  a_rem_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 16'd0) |-> (verdict_q == ST_OK) && (thw_q >= MIN_HDR_WORDS))
    else $error("payload countdown running on a rejected frame");

endmodule

>>> tb/sv/tcp_payload_extractor_checker.sv
`timescale 1ns / 100ps
// Watches both stream sides of the TCP payload extractor, predicts each result word and compares.
module tcp_payload_extractor_checker
  import tpe_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                      // [26:11] payload_length, [31:27] zero
  input  logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] frame_done
  input  logic        m_axis_tlast,   // payload_last
  output int          mismatches_o,
  output int          outstanding_o
);

  // Parse state of the frame in progress.
  int unsigned frame_pos     = 0;
  logic [3:0]  ip_hdr_words  = '0;
  logic [3:0]  tcp_hdr_words = '0;
  logic [7:0]  ip_proto      = '0;
  logic [15:0] ip_total_len  = '0;
  logic [15:0] payload_left  = '0;
  status_e     verdict       = ST_OK;

  // Result words still owed by the block, oldest first.
  result_t parsed_words[$];

  function automatic int payload_bytes();
    return int'(ip_total_len) - 4 * (int'(ip_hdr_words) + int'(tcp_hdr_words));
  endfunction

  function automatic void clear_frame_state();
    frame_pos     = 0;
    ip_hdr_words  = '0;
    tcp_hdr_words = '0;
    ip_proto      = '0;
    ip_total_len  = '0;
    payload_left  = '0;
    verdict       = ST_OK;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    int unsigned p;
    int          sz;
    logic        valid;
    logic        last;
    result_t     word;
    p     = frame_pos;
    valid = 1'b0;
    last  = 1'b0;
    if (p < MaxFrameBytes && verdict == ST_OK) begin
      if (p == ETH_HDR_BYTES) begin
        ip_hdr_words = b[3:0];
        if (ip_hdr_words < MIN_HDR_WORDS) verdict = ST_BAD_IP_HLEN;
      end else if (p == IP_LEN_HI_POS) begin
        ip_total_len[15:8] = b;
      end else if (p == IP_LEN_LO_POS) begin
        ip_total_len[7:0] = b;
      end else if (p == IP_PROTO_POS) begin
        ip_proto = b;
        if (ip_proto != PROTO_TCP) verdict = ST_NOT_TCP;
      end else if (p > ETH_HDR_BYTES && p == TCP_OFF_BASE + 4 * int'(ip_hdr_words)) begin
        tcp_hdr_words = b[7:4];
        if (tcp_hdr_words < MIN_HDR_WORDS) begin
          verdict = ST_BAD_TCP_HLEN;
        end else begin
          sz = payload_bytes();
          if (sz > 0) payload_left = sz[15:0];
          else verdict = ST_NO_PAYLOAD;
        end
      end else if (payload_left != 0 &&
                   p >= ETH_HDR_BYTES + 4 * (int'(ip_hdr_words) + int'(tcp_hdr_words))) begin
        valid        = 1'b1;
        payload_left = payload_left - 1'b1;
        last         = (payload_left == 0) || fin;
      end
    end
    if (frame_pos < MaxFrameBytes) frame_pos++;

    if (valid || fin) begin
      word = '0;
      word.payload_byte  = valid ? b : 8'd0;
      word.payload_valid = valid;
      word.payload_last  = last;
      word.frame_done    = fin;
      word.frame_status  = ST_OK;
      if (fin) begin
        if (verdict != ST_OK) word.frame_status = verdict;
        else if (tcp_hdr_words == 0 || payload_left != 0) word.frame_status = ST_TRUNCATED;
        // The length is reported when a valid TCP header length was seen and the payload size is positive.
        if (tcp_hdr_words >= MIN_HDR_WORDS) begin
          sz = payload_bytes();
          if (sz > 0) word.payload_length = sz[15:0];
        end
      end
      parsed_words.push_back(word);
    end
    if (fin) clear_frame_state();
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_frame_state();
      parsed_words.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      // A word leaving now always belongs to an earlier input, so compare before predicting.
      if (m_axis_tvalid && m_axis_tready) begin
        if (parsed_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches_o++;
        end else begin
          want = parsed_words.pop_front();
          check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
          check_field("frame_status", want.frame_status, m_axis_tdata[10:8]);
          check_field("payload_length", want.payload_length, m_axis_tdata[26:11]);
          check_field("tdata padding", 0, m_axis_tdata[31:27]);
          check_field("payload_valid", want.payload_valid, m_axis_tuser[0]);
          check_field("frame_done", want.frame_done, m_axis_tuser[1]);
          check_field("payload_last", want.payload_last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      outstanding_o = parsed_words.size();
    end
  end

endmodule

>>> tb/sv/tcp_payload_extractor_test.sv
`timescale 1ns / 100ps
// Top of the TCP payload extractor testbench: clock, reset, frame stimulus and verdict.
module tcp_payload_extractor_test;
  import tpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_BYTES = 140;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD   = 300;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  // Field offsets inside the IP and TCP headers.
  localparam int unsigned IP_LEN_HI_OFS  = IP_LEN_HI_POS - ETH_HDR_BYTES;
  localparam int unsigned IP_LEN_LO_OFS  = IP_LEN_LO_POS - ETH_HDR_BYTES;
  localparam int unsigned IP_PROTO_OFS   = IP_PROTO_POS - ETH_HDR_BYTES;
  localparam int unsigned TCP_DOFF_OFS   = TCP_OFF_BASE - ETH_HDR_BYTES;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tlast;   // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] payload_byte, [10:8] frame_status,
                               // [26:11] payload_length, [31:27] zero
  logic [1:0]  m_axis_tuser;   // [0] payload_valid, [1] frame_done
  logic        m_axis_tlast;   // payload_last

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int          send_idle_pct  = 13;
  int          recv_idle_pct  = 64;
  int          rx_hold_cycles = 0;
  logic [7:0]  frame_bytes[$];

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  tcp_payload_extractor #(
    .MaxFrameBytes(MAX_FRAME_BYTES)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  tcp_payload_extractor_checker #(
    .MaxFrameBytes(MAX_FRAME_BYTES)
  ) frame_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .mismatches_o(mismatches),
    .outstanding_o(outstanding)
  );

  // Receiver: random back-pressure, or a long hold-off counted down here.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tcp_payload_extractor verification failed");
    $finish;
  end

  // Lays out one frame; header lengths below the minimum still occupy the minimum size.
  function automatic void build_frame(input int ihl, input int doff, input logic [7:0] proto,
                                      input int total_len, input int payload, input int pad,
                                      input int cut);
    int          ip_bytes;
    int          tcp_bytes;
    logic [15:0] tl;
    ip_bytes  = 4 * ((ihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : ihl);
    tcp_bytes = 4 * ((doff < MIN_HDR_WORDS) ? MIN_HDR_WORDS : doff);
    tl        = total_len[15:0];
    frame_bytes.delete();
    repeat (ETH_HDR_BYTES) frame_bytes.push_back(8'($urandom));
    for (int i = 0; i < ip_bytes; i++) begin
      if (i == 0) frame_bytes.push_back({4'($urandom), 4'(ihl)});
      else if (i == IP_LEN_HI_OFS) frame_bytes.push_back(tl[15:8]);
      else if (i == IP_LEN_LO_OFS) frame_bytes.push_back(tl[7:0]);
      else if (i == IP_PROTO_OFS) frame_bytes.push_back(proto);
      else frame_bytes.push_back(8'($urandom));
    end
    for (int i = 0; i < tcp_bytes; i++) begin
      if (i == TCP_DOFF_OFS) frame_bytes.push_back({4'(doff), 4'($urandom)});
      else frame_bytes.push_back(8'($urandom));
    end
    repeat (payload + pad) frame_bytes.push_back(8'($urandom));
    if (cut > 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endfunction

  // Mostly well-formed frames with random content; the rest is broken or plain noise.
  function automatic void random_frame();
    int          kind;
    int          ihl;
    int          doff;
    int          payload;
    int          pad;
    int          total_len;
    int          cut;
    logic [7:0]  proto;
    kind      = $urandom_range(99);
    ihl       = ($urandom_range(3) == 0) ? $urandom_range(15, MIN_HDR_WORDS) : MIN_HDR_WORDS;
    doff      = ($urandom_range(3) == 0) ? $urandom_range(15, MIN_HDR_WORDS) : MIN_HDR_WORDS;
    payload   = $urandom_range(40, 1);
    pad       = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : 0;
    total_len = 4 * (ihl + doff) + payload;
    proto     = PROTO_TCP;
    cut       = 0;
    if (kind < 60) begin
    end else if (kind < 70) begin
      cut = $urandom_range(ETH_HDR_BYTES + total_len + pad - 1, 1);
    end else if (kind < 75) begin
      total_len = $urandom_range(4 * (ihl + doff));
    end else if (kind < 80) begin
      total_len = ($urandom_range(1) == 0) ? total_len + $urandom_range(60, 1)
                                           : $urandom_range(65535);
    end else if (kind < 85) begin
      ihl = $urandom_range(MIN_HDR_WORDS - 1);
    end else if (kind < 90) begin
      do proto = 8'($urandom); while (proto == PROTO_TCP);
    end else if (kind < 95) begin
      doff = $urandom_range(MIN_HDR_WORDS - 1);
    end
    build_frame(ihl, doff, proto, total_len, payload, pad, cut);
    if (kind >= 95) begin
      frame_bytes.delete();
      repeat ($urandom_range(70, 1)) frame_bytes.push_back(8'($urandom));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames: clean, padded, each rejection and the early endings.
    build_frame(5, 5, PROTO_TCP, 44, 4, 0, 0);            send_frame();
    build_frame(5, 5, PROTO_TCP, 43, 3, 6, 0);            send_frame();
    build_frame(4, 5, PROTO_TCP, 44, 4, 0, 16);           send_frame();
    build_frame(0, 5, PROTO_TCP, 44, 4, 0, 0);            send_frame();
    build_frame(5, 5, PROTO_UDP, 48, 8, 0, 30);           send_frame();
    build_frame(5, 4, PROTO_TCP, 60, 20, 0, 0);           send_frame();
    build_frame(5, 5, PROTO_TCP, 0, 0, 2, 0);             send_frame();
    build_frame(5, 5, PROTO_TCP, 40, 0, 0, 0);            send_frame();
    build_frame(15, 15, PROTO_TCP, 16'hffff, 5, 0, 0);    send_frame();
    build_frame(5, 5, PROTO_TCP, 44, 4, 0, 1);            send_frame();
    build_frame(5, 5, PROTO_TCP, 44, 4, 0, 15);           send_frame();
    build_frame(5, 5, PROTO_TCP, 44, 4, 0, 50);           send_frame();
    build_frame(5, 5, PROTO_TCP, 50, 10, 0, 60);          send_frame();
    drain();

    // The receiver holds off while a long payload keeps coming, so the input must stall.
    send_idle_pct  = 0;
    rx_hold_cycles = LONG_HOLD;
    build_frame(5, 5, PROTO_TCP, 190, 150, 0, 0);
    send_frame();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 13 : 0;
      bytes_sent    = 0;
      while (bytes_sent < PHASE_BYTES) begin
        random_frame();
        send_frame();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tcp_payload_extractor verification clean");
    end else begin
      $display("tcp_payload_extractor verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tpe_pkg.sv
design/tcp_payload_extractor.sv
tb/sv/tcp_payload_extractor_checker.sv
tb/sv/tcp_payload_extractor_test.sv
